// ----- rtl/chacha20_stream_cipher_macros.svh -----
// assertion macros
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH
`ifndef SYNTH
`define CC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/cc20_pkg.sv -----
package cc20_pkg;
	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR = 3'd6;
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;
	localparam int QDEPTH = 2;

	typedef logic [15:0][31:0] cc_state_t;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0] count;
		logic [2:0] pos;
		logic new_block;
		logic [31:0] ctr;
	} cc_cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		rotl = (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [127:0] quarter(input logic [127:0] x);
		logic [31:0] a, b, c, d;
		a = x[31:0]; b = x[63:32]; c = x[95:64]; d = x[127:96];
		a = a + b; d = rotl(d ^ a, 16);
		c = c + d; b = rotl(b ^ c, 12);
		a = a + b; d = rotl(d ^ a, 8);
		c = c + d; b = rotl(b ^ c, 7);
		quarter = {d, c, b, a};
	endfunction

	function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (cnt > 4'(i))
				m[i*8 +: 8] = 8'hff;
		end
		byte_mask = m;
	endfunction
endpackage

// ----- rtl/cc20_stream_if.sv -----
interface cc20_stream_if #(parameter int W = 64);
	logic valid;
	logic ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/cc20_front.sv -----
module cc20_front
	import cc20_pkg::*;
(
	input logic clk,
	input logic arst_n,
	cc20_stream_if.sink in_ch,
	input logic [31:0] init_ctr,
	output logic cmd_valid,
	input logic cmd_ready,
	output cc_cmd_t cmd
);
	logic [2:0] pos_q;
	logic ready_q;
	logic [31:0] ctr_q;
	logic start;
	logic need_block;
	logic [2:0] pos_eff;
	logic [31:0] ctr_eff;

	assign start = in_ch.payload[4];
	assign pos_eff = start ? 3'd0 : pos_q;
	assign need_block = start || !ready_q;
	assign ctr_eff = start ? init_ctr : ctr_q;
	assign cmd_valid = in_ch.valid;
	assign in_ch.ready = cmd_ready;
	assign cmd.data = in_ch.payload[68:5];
	assign cmd.count = in_ch.payload[3:0];
	assign cmd.pos = pos_eff;
	assign cmd.new_block = need_block;
	assign cmd.ctr = ctr_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ready_q <= 1'b0;
			ctr_q <= '0;
		end else if (in_ch.valid && cmd_ready) begin
			pos_q <= pos_eff + 3'd1;
			ready_q <= (pos_eff != 3'd7);
			if (need_block)
				ctr_q <= ctr_eff + 32'd1;
		end
	end
endmodule

// ----- rtl/cc20_queue.sv -----
module cc20_queue
	import cc20_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cc_cmd_t in_cmd,
	output logic out_valid,
	input logic out_ready,
	output cc_cmd_t out_cmd
);
	cc_cmd_t mem_q [QDEPTH];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'(QDEPTH);
	assign out_valid = cnt_q != 2'd0;
	assign out_cmd = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- rtl/cc20_back.sv -----
module cc20_back
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input cc_cmd_t cmd,
	input logic [255:0] key,
	input logic [95:0] nonce,
	cc20_stream_if.source out_ch
);
	localparam int RW = $clog2(2 * DOUBLE_ROUNDS + 1);

	cc_state_t init_q, work_q, block_q;
	logic busy_q;
	logic gen_done_q;
	logic [RW-1:0] round_q;
	logic out_valid_q;
	logic [67:0] out_q;
	cc_state_t rnd;
	cc_state_t init_c;
	logic [63:0] ks;
	logic can_out;
	logic gen_start;
	logic last_round;

	assign init_c = {nonce[95:64], nonce[63:32], nonce[31:0], cmd.ctr, key[255:224],
		key[223:192], key[191:160], key[159:128], key[127:96], key[95:64], key[63:32],
		key[31:0], SIGMA3, SIGMA2, SIGMA1, SIGMA0};

	always_comb begin
		logic [127:0] q0, q1, q2, q3;
		rnd = work_q;
		if (!round_q[0]) begin
			q0 = quarter({work_q[12], work_q[8], work_q[4], work_q[0]});
			q1 = quarter({work_q[13], work_q[9], work_q[5], work_q[1]});
			q2 = quarter({work_q[14], work_q[10], work_q[6], work_q[2]});
			q3 = quarter({work_q[15], work_q[11], work_q[7], work_q[3]});
			{rnd[12], rnd[8], rnd[4], rnd[0]} = q0;
			{rnd[13], rnd[9], rnd[5], rnd[1]} = q1;
			{rnd[14], rnd[10], rnd[6], rnd[2]} = q2;
			{rnd[15], rnd[11], rnd[7], rnd[3]} = q3;
		end else begin
			q0 = quarter({work_q[15], work_q[10], work_q[5], work_q[0]});
			q1 = quarter({work_q[12], work_q[11], work_q[6], work_q[1]});
			q2 = quarter({work_q[13], work_q[8], work_q[7], work_q[2]});
			q3 = quarter({work_q[14], work_q[9], work_q[4], work_q[3]});
			{rnd[15], rnd[10], rnd[5], rnd[0]} = q0;
			{rnd[12], rnd[11], rnd[6], rnd[1]} = q1;
			{rnd[13], rnd[8], rnd[7], rnd[2]} = q2;
			{rnd[14], rnd[9], rnd[4], rnd[3]} = q3;
		end
	end

	assign ks = {block_q[{cmd.pos, 1'b1}], block_q[{cmd.pos, 1'b0}]};
	assign can_out = !out_valid_q || out_ch.ready;
	assign gen_start = cmd_valid && !busy_q && cmd.new_block && !gen_done_q;
	assign last_round = busy_q && round_q == RW'(2 * DOUBLE_ROUNDS - 1);
	assign cmd_ready = cmd_valid && !busy_q && (!cmd.new_block || gen_done_q) && can_out;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	always_ff @(posedge clk) begin
		if (gen_start) begin
			init_q <= init_c;
			work_q <= init_c;
		end else if (busy_q) begin
			work_q <= rnd;
		end
		if (last_round) begin
			for (int k = 0; k < 16; k++)
				block_q[k] <= rnd[k] + init_q[k];
		end
		if (cmd_ready)
			out_q <= {(cmd.data ^ ks) & byte_mask(cmd.count), cmd.count};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			gen_done_q <= 1'b0;
			round_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (gen_start) begin
				busy_q <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + RW'(1);
				if (last_round)
					busy_q <= 1'b0;
			end
			if (last_round)
				gen_done_q <= 1'b1;
			else if (cmd_ready)
				gen_done_q <= 1'b0;
			if (cmd_ready)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

// ----- rtl/chacha20_stream_cipher.sv -----
// path: front, queue and registered back end; a word that starts a block is held until its block is generated
// throughput: one word a cycle within a block while the receiver is ready; each block of eight words
// adds a stall while the one-half-round-per-cycle core generates its keystream
// reset: arst_n clears counter, word position, queue and output valid; keys clear to zero
module chacha20_stream_cipher
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	cc20_stream_if.sink in_ch,
	cc20_stream_if.source out_ch
);
`include "chacha20_stream_cipher_macros.svh"
	logic [255:0] key_q;
	logic [95:0] nonce_q;
	logic [31:0] init_ctr_q;
	logic f_valid, f_ready, b_valid, b_ready;
	cc_cmd_t f_cmd, b_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			nonce_q <= '0;
			init_ctr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KEY0: key_q[63:0] <= cfg_wdata;
				REG_KEY1: key_q[127:64] <= cfg_wdata;
				REG_KEY2: key_q[191:128] <= cfg_wdata;
				REG_KEY3: key_q[255:192] <= cfg_wdata;
				REG_NONCE_LO: nonce_q[63:0] <= cfg_wdata;
				REG_NONCE_HI: nonce_q[95:64] <= cfg_wdata[31:0];
				REG_INIT_CTR: init_ctr_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	cc20_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .init_ctr(init_ctr_q),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	cc20_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_ready(f_ready),
		.in_cmd(f_cmd), .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
	);

	cc20_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(b_valid), .cmd_ready(b_ready),
		.cmd(b_cmd), .key(key_q), .nonce(nonce_q), .out_ch(out_ch)
	);

	`CC_ASSERT_IMPL(a_ready_needs_valid, clk, arst_n, b_ready, b_valid && !u_back.busy_q)
	`CC_ASSERT_NEXT(a_out_after_issue, clk, arst_n, b_ready, out_ch.valid)
	`CC_ASSERT_IMPL(a_front_holds, clk, arst_n, f_valid && !f_ready, !b_ready || b_valid)
endmodule

// ----- tb/sv/chacha20_stream_cipher_tb.sv -----
module chacha20_stream_cipher_tb;
	import cc20_pkg::*;

	localparam int IN_W = 69;
	localparam int OUT_W = 68;
	localparam int DRAIN_CYCLES = 2 * DOUBLE_ROUNDS_DEF + 10;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0] count;
	} cipher_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cc20_stream_if #(.W(IN_W)) in_ch ();
	cc20_stream_if #(.W(OUT_W)) out_ch ();

	chacha20_stream_cipher i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// cipher model state
	logic [63:0] key_reg[4];
	logic [63:0] nonce_lo_reg;
	logic [31:0] nonce_hi_reg;
	logic [31:0] init_ctr_reg;
	logic [31:0] keystream[16];
	logic [31:0] mix[16];
	logic [31:0] blk_ctr;
	logic [2:0] word_pos;
	logic have_block;

	cipher_word_t expected_words[$];
	int mismatches;
	int words_sent;
	int words_checked;
	int blocks_made;
	int starts_sent;
	int rx_hold;
	bit rx_no_stall;
	bit tx_no_gap;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function void mix_quarter(input int a, input int b, input int c, input int d);
		mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 16);
		mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 12);
		mix[a] = mix[a] + mix[b]; mix[d] = rol32(mix[d] ^ mix[a], 8);
		mix[c] = mix[c] + mix[d]; mix[b] = rol32(mix[b] ^ mix[c], 7);
	endfunction

	function void generate_block();
		logic [31:0] init_words[16];
		init_words[0] = 32'h61707865;
		init_words[1] = 32'h3320646e;
		init_words[2] = 32'h79622d32;
		init_words[3] = 32'h6b206574;
		for (int k = 0; k < 4; k++) begin
			init_words[4 + 2*k] = key_reg[k][31:0];
			init_words[5 + 2*k] = key_reg[k][63:32];
		end
		init_words[12] = blk_ctr;
		init_words[13] = nonce_lo_reg[31:0];
		init_words[14] = nonce_lo_reg[63:32];
		init_words[15] = nonce_hi_reg;
		for (int k = 0; k < 16; k++)
			mix[k] = init_words[k];
		for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
			mix_quarter(0, 4, 8, 12);
			mix_quarter(1, 5, 9, 13);
			mix_quarter(2, 6, 10, 14);
			mix_quarter(3, 7, 11, 15);
			mix_quarter(0, 5, 10, 15);
			mix_quarter(1, 6, 11, 12);
			mix_quarter(2, 7, 8, 13);
			mix_quarter(3, 4, 9, 14);
		end
		for (int k = 0; k < 16; k++)
			keystream[k] = mix[k] + init_words[k];
		blocks_made++;
	endfunction

	function automatic cipher_word_t encrypt_word(input logic [63:0] data,
			input logic [3:0] count, input logic start);
		cipher_word_t res;
		logic [63:0] stream;
		logic [63:0] mask;
		if (start) begin
			blk_ctr = init_ctr_reg;
			word_pos = 3'd0;
			have_block = 1'b0;
		end
		if (!have_block) begin
			generate_block();
			blk_ctr = blk_ctr + 32'd1;
			have_block = 1'b1;
		end
		stream = {keystream[2*word_pos + 1], keystream[2*word_pos]};
		mask = '0;
		for (int i = 0; i < 8; i++)
			if (count > i)
				mask[i*8 +: 8] = 8'hff;
		res.data = (data ^ stream) & mask;
		res.count = count;
		word_pos = word_pos + 3'd1;
		if (word_pos == 3'd0)
			have_block = 1'b0;
		return res;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_KEY0: key_reg[0] = val;
			REG_KEY1: key_reg[1] = val;
			REG_KEY2: key_reg[2] = val;
			REG_KEY3: key_reg[3] = val;
			REG_NONCE_LO: nonce_lo_reg = val;
			REG_NONCE_HI: nonce_hi_reg = val[31:0];
			REG_INIT_CTR: init_ctr_reg = val[31:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_key_nonce(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] n_lo,
			input logic [31:0] n_hi, input logic [31:0] ctr);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_NONCE_LO, n_lo);
		write_reg(REG_NONCE_HI, {32'd0, n_hi});
		write_reg(REG_INIT_CTR, {32'd0, ctr});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic wait_drained();
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_word(input logic [63:0] data, input logic [3:0] count,
			input logic start);
		int gap;
		gap = tx_no_gap ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= {data, start, count};
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		expected_words.push_back(encrypt_word(data, count, start));
		words_sent++;
		if (start)
			starts_sent++;
	endtask

	task automatic stop_sending();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_message(input int words, input bit short_tail);
		for (int i = 0; i < words; i++)
			send_word(rand64(),
				(short_tail && i == words - 1) ? 4'($urandom_range(1, 7)) : 4'd8,
				i == 0);
	endtask

	// output checker and receiver stalls
	initial begin
		int wait_left;
		cipher_word_t got;
		cipher_word_t want;
		wait_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got = out_ch.payload;
				words_checked++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: data %h count %0d", got.data, got.count);
				end else begin
					want = expected_words.pop_front();
					if (got.data !== want.data || got.count !== want.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected data %h count %0d, got data %h count %0d",
								want.data, want.count, got.data, got.count);
					end
				end
				wait_left = rx_no_stall ? 0 : $urandom_range(0, 4);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ch.ready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic test_directed();
		load_key_nonce('0, '0, '0, '0, '0, '0, '0);
		send_word(64'h0, 4'd8, 1'b1);
		send_word('1, 4'd8, 1'b0);
		for (int c = 0; c < 16; c++)
			send_word(rand64(), 4'(c), 1'b0);
		stop_sending();
		wait_drained();
		// counter wrap with all-ones key and nonce, restart mid block
		load_key_nonce('1, '1, '1, '1, '1, '1, '1);
		send_word('1, 4'd8, 1'b1);
		send_word(rand64(), 4'd8, 1'b0);
		send_word(rand64(), 4'd3, 1'b1);
		for (int i = 0; i < 9; i++)
			send_word(rand64(), 4'd8, 1'b0);
		stop_sending();
		wait_drained();
	endtask

	task automatic test_random_traffic(input int phases);
		int budget;
		for (int p = 0; p < phases; p++) begin
			load_key_nonce(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom,
				($urandom_range(0, 3) == 0) ? 32'hffffffff - $urandom_range(0, 2) : $urandom);
			rx_no_stall = (p % 4 == 1);
			tx_no_gap = (p % 4 == 2);
			budget = 90;
			while (budget > 0) begin
				if ($urandom_range(0, 9) == 0) begin
					send_word(rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
					budget--;
				end else begin
					int n;
					n = $urandom_range(1, 20);
					send_message(n, $urandom_range(0, 1));
					budget -= n;
				end
			end
			stop_sending();
			wait_drained();
		end
		rx_no_stall = 1'b0;
		tx_no_gap = 1'b0;
	endtask

	task automatic test_backpressure();
		tx_no_gap = 1'b1;
		rx_hold = 300;
		send_message(40, 1'b0);
		stop_sending();
		tx_no_gap = 1'b0;
		wait_drained();
	endtask

	task automatic test_pause_until_drained();
		send_message(12, 1'b1);
		stop_sending();
		while (expected_words.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 12; i++)
			send_word(rand64(), 4'd8, 1'b0);
		stop_sending();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		out_ch.ready <= 1'b0;
		key_reg = '{default: '0};
		nonce_lo_reg = '0;
		nonce_hi_reg = '0;
		init_ctr_reg = '0;
		blk_ctr = '0;
		word_pos = '0;
		have_block = 1'b0;
		mismatches = 0;
		words_sent = 0;
		words_checked = 0;
		blocks_made = 0;
		starts_sent = 0;
		rx_hold = 0;
		rx_no_stall = 1'b0;
		tx_no_gap = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_pause_until_drained();
		test_random_traffic(8);

		wait_drained();
		if (expected_words.size() != 0)
			mismatches++;
		$display("%0d words in, %0d checked, %0d message starts, %0d keystream blocks",
			words_sent, words_checked, starts_sent, blocks_made);
		$display("covered counter wrap, short and oversize counts, restarts, long stalls");
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
